FILE: sv/mqtt_resp_pkg.sv
// Shared types and constants for the MQTT control packet responder.
// Holds parser phase codes, packet type codes, response codes and the result beat type.
// No dependencies.
`default_nettype none

package mqtt_resp_pkg;

   localparam int PHASE_W = 4;

   localparam logic [PHASE_W-1:0] PH_HEADER     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_LENGTH     = 4'd1;
   localparam logic [PHASE_W-1:0] PH_SKIP       = 4'd2;
   localparam logic [PHASE_W-1:0] PH_ID_HI      = 4'd3;
   localparam logic [PHASE_W-1:0] PH_ID_LO      = 4'd4;
   localparam logic [PHASE_W-1:0] PH_TOPIC_HI   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_TOPIC_LO   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_TOPIC_BODY = 4'd7;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD    = 4'd8;

   localparam logic [3:0] KIND_CONNECT     = 4'd1;
   localparam logic [3:0] KIND_PUBLISH     = 4'd3;
   localparam logic [3:0] KIND_PUBREL      = 4'd6;
   localparam logic [3:0] KIND_SUBSCRIBE   = 4'd8;
   localparam logic [3:0] KIND_UNSUBSCRIBE = 4'd10;
   localparam logic [3:0] KIND_PINGREQ     = 4'd12;

   localparam logic [7:0] CODE_CONNACK  = 8'h20;
   localparam logic [7:0] CODE_PUBACK   = 8'h40;
   localparam logic [7:0] CODE_PUBREC   = 8'h50;
   localparam logic [7:0] CODE_PUBCOMP  = 8'h70;
   localparam logic [7:0] CODE_SUBACK   = 8'h90;
   localparam logic [7:0] CODE_UNSUBACK = 8'hB0;
   localparam logic [7:0] CODE_PINGRESP = 8'hD0;

   localparam logic [1:0] REG_TOPIC_LIMIT   = 2'd0;
   localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd1;
   localparam logic [1:0] REG_SUB_LIMIT     = 2'd2;
   localparam logic [1:0] REG_UNSUB_LIMIT   = 2'd3;

   localparam logic [15:0] TOPIC_LIMIT_RST   = 16'd1024;
   localparam logic [27:0] PAYLOAD_LIMIT_RST = 28'd8192;
   localparam logic [27:0] SUB_LIMIT_RST     = 28'd1024;
   localparam logic [27:0] UNSUB_LIMIT_RST   = 28'd1025;

   localparam logic OUT_RESPONSE = 1'b0;
   localparam logic OUT_PAYLOAD  = 1'b1;

   // Most result beats a single input byte can cause (SUBACK).
   localparam int QUEUE_DEPTH = 5;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
      logic       conn;
   } beat_type;

   function automatic beat_type make_beat(input logic kind, input logic [7:0] data,
                                          input logic last, input logic conn);
      beat_type bt;
      bt.kind = kind;
      bt.data = data;
      bt.last = last;
      bt.conn = conn;
      return bt;
   endfunction

endpackage

`default_nettype wire

FILE: sv/mqtt_control_packet_responder.sv
// Top level of the MQTT control packet responder: byte parser and result queue.
// Depends on mqtt_resp_pkg.
//
// Latency: a result beat is presented the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle when it causes at most one beat and rsp_tready is high;
// after a byte that causes more beats (CONNACK, PINGRESP, id replies, SUBACK, up to five)
// the input stays blocked while the queue drains, one beat per cycle with rsp_tready high.
// Reset (synchronous, active high) returns the parser to the fixed header, clears the
// connected flag, empties the queue and restores the default limits.
`default_nettype none

module mqtt_control_packet_responder
   import mqtt_resp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_data, [8] session_connected, rest zero
   output logic             rsp_tuser,   // [0] out_kind
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [27:0] csr_wdata
);

   // Configuration.
   logic [15:0] topic_limit_ff;
   logic [27:0] payload_limit_ff;
   logic [27:0] sub_limit_ff;
   logic [27:0] unsub_limit_ff;

   // Parser state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         kind_ff, kind_in;
   logic [1:0]         qos_ff, qos_in;
   logic [27:0]        rem_ff, rem_in;
   logic [2:0]         lcnt_ff, lcnt_in;
   logic [27:0]        left_ff, left_in;
   logic [15:0]        topic_ff, topic_in;
   logic [7:0]         id_hi_ff, id_hi_in;
   logic               fwd_ff, fwd_in;
   logic               conn_ff, conn_in;

   // Result queue; entry 0 is the beat on the bus.
   beat_type           q_ff [QUEUE_DEPTH];
   beat_type           q_in [QUEUE_DEPTH];
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   beat_type           resp [QUEUE_DEPTH];
   logic [COUNT_W-1:0] resp_n;

   logic               req_fire;
   logic               rsp_fire;
   logic [7:0]         rx_byte;
   logic [27:0]        len_part;
   logic [27:0]        rem_next;
   logic [2:0]         lcnt_next;
   logic [27:0]        left_dec;
   logic [15:0]        topic_full;
   logic [15:0]        topic_dec;
   logic [1:0]         qos_lvl;
   logic [27:0]        pay_sub;
   logic [27:0]        pay_len;
   logic               pay_ok;
   logic [7:0]         reply_code;

   assign rx_byte    = req_tdata;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   // The input is taken whenever the queue is empty or its last beat leaves now.
   assign req_tready = (cnt_ff == '0) || ((cnt_ff == COUNT_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tdata = {7'd0, q_ff[0].conn, q_ff[0].data};
   assign rsp_tuser = q_ff[0].kind;
   assign rsp_tlast = q_ff[0].last;

   // QoS 3 behaves as QoS 0.
   assign qos_lvl = (qos_ff == 2'd3) ? 2'd0 : qos_ff;

   always_comb begin
      case (lcnt_ff[1:0])
         2'd0:    len_part = {21'd0, rx_byte[6:0]};
         2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
         2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
         default: len_part = {rx_byte[6:0], 21'd0};
      endcase
   end

   assign rem_next   = rem_ff | len_part;
   assign lcnt_next  = lcnt_ff + 3'd1;
   assign left_dec   = left_ff - 28'd1;
   assign topic_full = {topic_ff[15:8], rx_byte};
   assign topic_dec  = topic_ff - 16'd1;

   // Payload length is the remaining length less the topic field and the packet id.
   assign pay_sub = {12'd0, topic_full} + 28'd2 + ((qos_lvl != 2'd0) ? 28'd2 : 28'd0);
   assign pay_len = rem_ff - pay_sub;
   assign pay_ok  = (rem_ff >= pay_sub) && (pay_len <= payload_limit_ff);

   assign reply_code = (kind_ff == KIND_PUBLISH)
                          ? ((qos_lvl == 2'd1) ? CODE_PUBACK : CODE_PUBREC)
                          : ((kind_ff == KIND_PUBREL) ? CODE_PUBCOMP : CODE_UNSUBACK);

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      qos_in   = qos_ff;
      rem_in   = rem_ff;
      lcnt_in  = lcnt_ff;
      left_in  = left_ff;
      topic_in = topic_ff;
      id_hi_in = id_hi_ff;
      fwd_in   = fwd_ff;
      conn_in  = conn_ff;
      resp_n   = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         resp[i] = '0;
      end

      if (req_fire) begin
         case (phase_ff)
            PH_HEADER: begin
               kind_in  = rx_byte[7:4];
               qos_in   = rx_byte[2:1];
               rem_in   = '0;
               lcnt_in  = '0;
               fwd_in   = 1'b0;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               rem_in  = rem_next;
               lcnt_in = lcnt_next;
               if (rx_byte[7]) begin
                  // A length field longer than four bytes drops the packet.
                  if (lcnt_next >= 3'd4) begin
                     phase_in = PH_HEADER;
                  end
               end else begin
                  left_in  = rem_next;
                  phase_in = PH_SKIP;
                  case (kind_ff)
                     KIND_CONNECT: begin
                        conn_in = 1'b1;
                        resp_n  = COUNT_W'(4);
                        resp[0] = make_beat(OUT_RESPONSE, CODE_CONNACK, 1'b0, 1'b1);
                        resp[1] = make_beat(OUT_RESPONSE, 8'h02, 1'b0, 1'b1);
                        resp[2] = make_beat(OUT_RESPONSE, 8'h00, 1'b0, 1'b1);
                        resp[3] = make_beat(OUT_RESPONSE, 8'h00, 1'b1, 1'b1);
                     end
                     KIND_PINGREQ: begin
                        resp_n  = COUNT_W'(2);
                        resp[0] = make_beat(OUT_RESPONSE, CODE_PINGRESP, 1'b0, conn_ff);
                        resp[1] = make_beat(OUT_RESPONSE, 8'h00, 1'b1, conn_ff);
                     end
                     KIND_PUBLISH: phase_in = PH_TOPIC_HI;
                     KIND_PUBREL:  phase_in = PH_ID_HI;
                     KIND_SUBSCRIBE: begin
                        if (rem_next <= sub_limit_ff) begin
                           phase_in = PH_ID_HI;
                        end
                     end
                     KIND_UNSUBSCRIBE: begin
                        if (rem_next <= unsub_limit_ff) begin
                           phase_in = PH_ID_HI;
                        end
                     end
                     default: ;
                  endcase
                  if (rem_next == '0) begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            default: begin
               left_in = left_dec;
               case (phase_ff)
                  PH_TOPIC_HI: begin
                     topic_in = {rx_byte, 8'd0};
                     phase_in = PH_TOPIC_LO;
                  end
                  PH_TOPIC_LO: begin
                     topic_in = topic_full;
                     if (topic_full > topic_limit_ff) begin
                        phase_in = PH_SKIP;
                     end else begin
                        fwd_in = pay_ok;
                        if (topic_full != '0) begin
                           phase_in = PH_TOPIC_BODY;
                        end else if (qos_lvl != 2'd0) begin
                           phase_in = PH_ID_HI;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  PH_TOPIC_BODY: begin
                     topic_in = topic_dec;
                     if (topic_dec == '0) begin
                        phase_in = (qos_lvl != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
                     end
                  end
                  PH_ID_HI: begin
                     id_hi_in = rx_byte;
                     phase_in = PH_ID_LO;
                  end
                  PH_ID_LO: begin
                     phase_in = PH_SKIP;
                     if (kind_ff == KIND_SUBSCRIBE) begin
                        resp_n  = COUNT_W'(5);
                        resp[0] = make_beat(OUT_RESPONSE, CODE_SUBACK, 1'b0, conn_ff);
                        resp[1] = make_beat(OUT_RESPONSE, 8'h03, 1'b0, conn_ff);
                        resp[2] = make_beat(OUT_RESPONSE, id_hi_ff, 1'b0, conn_ff);
                        resp[3] = make_beat(OUT_RESPONSE, rx_byte, 1'b0, conn_ff);
                        resp[4] = make_beat(OUT_RESPONSE, 8'h00, 1'b1, conn_ff);
                     end else begin
                        resp_n  = COUNT_W'(4);
                        resp[0] = make_beat(OUT_RESPONSE, reply_code, 1'b0, conn_ff);
                        resp[1] = make_beat(OUT_RESPONSE, 8'h02, 1'b0, conn_ff);
                        resp[2] = make_beat(OUT_RESPONSE, id_hi_ff, 1'b0, conn_ff);
                        resp[3] = make_beat(OUT_RESPONSE, rx_byte, 1'b1, conn_ff);
                        if (kind_ff == KIND_PUBLISH) begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     if (fwd_ff) begin
                        resp_n  = COUNT_W'(1);
                        resp[0] = make_beat(OUT_PAYLOAD, rx_byte, (left_dec == '0), conn_ff);
                     end
                  end
                  default: ;
               endcase
               if (left_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (req_fire) begin
         cnt_in = resp_n;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_in[i] = resp[i];
         end
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - COUNT_W'(1);
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         topic_limit_ff   <= TOPIC_LIMIT_RST;
         payload_limit_ff <= PAYLOAD_LIMIT_RST;
         sub_limit_ff     <= SUB_LIMIT_RST;
         unsub_limit_ff   <= UNSUB_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_TOPIC_LIMIT:   topic_limit_ff   <= csr_wdata[15:0];
            REG_PAYLOAD_LIMIT: payload_limit_ff <= csr_wdata;
            REG_SUB_LIMIT:     sub_limit_ff     <= csr_wdata;
            REG_UNSUB_LIMIT:   unsub_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         kind_ff  <= '0;
         qos_ff   <= '0;
         rem_ff   <= '0;
         lcnt_ff  <= '0;
         left_ff  <= '0;
         topic_ff <= '0;
         id_hi_ff <= '0;
         fwd_ff   <= 1'b0;
         conn_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         qos_ff   <= qos_in;
         rem_ff   <= rem_in;
         lcnt_ff  <= lcnt_in;
         left_ff  <= left_in;
         topic_ff <= topic_in;
         id_hi_ff <= id_hi_in;
         fwd_ff   <= fwd_in;
         conn_ff  <= conn_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

`default_nettype wire
